// ===== rtl/core/bpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bpf_pkg
// Shared types, constants and the controller/datapath interface of the
// Bezier path flattener.
// ----------------------------------------------------------------------------
package bpf_pkg;

   localparam int COORD_W          = 32;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int SEG_CFG_W        = 7;
   localparam int CSR_IDX_W        = 1;
   localparam int KIND_W           = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_AT_END  = 1'b1;

   localparam logic [SEG_CFG_W-1:0] SEG_CFG_RESET = 7'd16;

   typedef enum logic [2:0] {
      FUNC_MOVE  = 3'd0,
      FUNC_LINE  = 3'd1,
      FUNC_CUBIC = 3'd2,
      FUNC_QUAD  = 3'd3,
      FUNC_CLOSE = 3'd4,
      FUNC_END   = 3'd5
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_CONT  = 2'd0,
      KIND_FIRST = 2'd1,
      KIND_MARK  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      SRC_END,
      SRC_START,
      SRC_FIRST,
      SRC_CURVE,
      SRC_MARK
   } src_type;

   typedef enum logic [1:0] {
      PEN_HOLD,
      PEN_END,
      PEN_START
   } pen_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEC,
      ST_MPRE,
      ST_PT_END,
      ST_PT_START,
      ST_PT_FIRST,
      ST_MARK,
      ST_CLR,
      ST_WA,
      ST_WB,
      ST_MAC,
      ST_DVI,
      ST_DIV,
      ST_CPT
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       emit;
      src_type    src;
      logic       last;
      pen_op_type pen_op;
      logic       set_start;
      logic       clear_path;
      logic       init_curve;
      logic       wt_a;
      logic       wt_b;
      logic       mac_step;
      logic       div_init;
      logic       div_step;
      logic       seg_next;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       open;
      logic       pen_eq_start;
      logic       first_eq_last;
      logic       close_at_end;
      logic       out_free;
      logic       mac_last;
      logic       div_done;
      logic       axis;
      logic       seg_last;
   } ctl_sts_type;

endpackage

// ===== rtl/core/bpf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpf_ctrl
// Command sequencer: walks each path command through its emit steps and,
// for curves, through weight, multiply-accumulate and divide steps.
// ----------------------------------------------------------------------------
module bpf_ctrl
   import bpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ctl_sts_type sts,
   output ctl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DEC;
         end
         ST_DEC: begin
            case (sts.func) inside
               FUNC_MOVE:  state_in = sts.open ? ST_MPRE : ST_PT_END;
               FUNC_LINE:  state_in = ST_PT_END;
               FUNC_CUBIC,
               FUNC_QUAD:  state_in = ST_WA;
               FUNC_CLOSE: begin
                  if (!sts.pen_eq_start) state_in = ST_PT_START;
                  else if (sts.open)     state_in = ST_MARK;
                  else                   state_in = ST_IDLE;
               end
               FUNC_END: begin
                  if (!sts.open) state_in = ST_CLR;
                  else if (sts.close_at_end && !sts.first_eq_last) state_in = ST_PT_FIRST;
                  else state_in = ST_MARK;
               end
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_MPRE:     if (sts.out_free) state_in = ST_PT_END;
         ST_PT_END:   if (sts.out_free) state_in = ST_IDLE;
         ST_PT_START: if (sts.out_free) state_in = ST_MARK;
         ST_PT_FIRST: if (sts.out_free) state_in = ST_MARK;
         ST_MARK: begin
            if (sts.out_free) state_in = (sts.func == FUNC_END) ? ST_CLR : ST_IDLE;
         end
         ST_CLR:      state_in = ST_IDLE;
         ST_WA:       state_in = ST_WB;
         ST_WB:       state_in = ST_MAC;
         ST_MAC:      if (sts.mac_last) state_in = ST_DVI;
         ST_DVI:      state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_done) state_in = sts.axis ? ST_CPT : ST_MAC;
         end
         ST_CPT: begin
            if (sts.out_free) state_in = sts.seg_last ? ST_IDLE : ST_WA;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.src    = SRC_MARK;
      cmd.pen_op = PEN_HOLD;
      unique case (state_ff)
         ST_IDLE: cmd.load_req = req_valid;
         ST_DEC: begin
            cmd.init_curve = (sts.func == FUNC_CUBIC) || (sts.func == FUNC_QUAD);
         end
         ST_MPRE: begin
            cmd.emit = sts.out_free;
            cmd.src  = SRC_MARK;
         end
         ST_PT_END: begin
            cmd.emit      = sts.out_free;
            cmd.src       = SRC_END;
            cmd.last      = 1'b1;
            cmd.pen_op    = PEN_END;
            cmd.set_start = (sts.func == FUNC_MOVE);
         end
         ST_PT_START: begin
            cmd.emit   = sts.out_free;
            cmd.src    = SRC_START;
            cmd.pen_op = PEN_START;
         end
         ST_PT_FIRST: begin
            cmd.emit = sts.out_free;
            cmd.src  = SRC_FIRST;
         end
         ST_MARK: begin
            cmd.emit = sts.out_free;
            cmd.src  = SRC_MARK;
            cmd.last = 1'b1;
         end
         ST_CLR:  cmd.clear_path = 1'b1;
         ST_WA:   cmd.wt_a       = 1'b1;
         ST_WB:   cmd.wt_b       = 1'b1;
         ST_MAC:  cmd.mac_step   = 1'b1;
         ST_DVI:  cmd.div_init   = 1'b1;
         ST_DIV:  cmd.div_step   = 1'b1;
         ST_CPT: begin
            cmd.emit     = sts.out_free;
            cmd.src      = SRC_CURVE;
            cmd.last     = sts.seg_last;
            cmd.pen_op   = sts.seg_last ? PEN_END : PEN_HOLD;
            cmd.seg_next = sts.out_free && !sts.seg_last;
         end
         default: cmd.src = SRC_MARK;
      endcase
   end

endmodule

// ===== rtl/core/bpf_datapath.sv =====
// ----------------------------------------------------------------------------
// bpf_datapath
// Path state, configuration registers, curve weight generator, one shared
// multiply-accumulate unit, a radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module bpf_datapath
   import bpf_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output ctl_sts_type          sts,
   input  logic [2:0]           req_func,
   input  logic [COORD_W-1:0]   req_end_x,
   input  logic [COORD_W-1:0]   req_end_y,
   input  logic [COORD_W-1:0]   req_ctrl1_x,
   input  logic [COORD_W-1:0]   req_ctrl1_y,
   input  logic [COORD_W-1:0]   req_ctrl2_x,
   input  logic [COORD_W-1:0]   req_ctrl2_y,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEG_CFG_W-1:0] csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COORD_W-1:0]   rsp_point_x,
   output logic [COORD_W-1:0]   rsp_point_y,
   output logic [KIND_W-1:0]    rsp_point_kind,
   output logic                 rsp_last_of_run
);

   localparam int SEG_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int WT_W   = 3 * SEG_W;
   localparam int PROD_W = COORD_W + WT_W + 1;
   localparam int ACC_W  = COORD_W + WT_W + 3;
   localparam int DV_W   = ACC_W + 2;
   localparam int QB     = COORD_W + 1;
   localparam int RM_W   = WT_W + 2;
   localparam int DCNT_W = $clog2(QB);
   localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

   // configuration
   logic [SEG_CFG_W-1:0] seg_cfg_ff;
   logic                 cae_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cfg_ff <= SEG_CFG_RESET;
         cae_ff     <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_SEGMENT_COUNT) seg_cfg_ff <= csr_wdata;
         if (csr_index == CSR_CLOSE_AT_END)  cae_ff     <= csr_wdata[0];
      end
   end

   logic [SEG_W-1:0] seg_n;
   always_comb begin
      if (seg_cfg_ff == '0) begin
         seg_n = SEG_W'(1);
      end else if ({{(32-SEG_CFG_W){1'b0}}, seg_cfg_ff} > MAX_SEGMENTS) begin
         seg_n = SEG_MAX;
      end else begin
         seg_n = SEG_W'(seg_cfg_ff);
      end
   end

   // captured command
   logic [2:0]         func_ff;
   logic [COORD_W-1:0] ex_ff, ey_ff, c1x_ff, c1y_ff, c2x_ff, c2y_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         ex_ff   <= req_end_x;
         ey_ff   <= req_end_y;
         c1x_ff  <= req_ctrl1_x;
         c1y_ff  <= req_ctrl1_y;
         c2x_ff  <= req_ctrl2_x;
         c2y_ff  <= req_ctrl2_y;
      end
   end

   // path state
   logic [COORD_W-1:0] pen_x_ff, pen_y_ff, start_x_ff, start_y_ff;
   logic [COORD_W-1:0] first_x_ff, first_y_ff, last_x_ff, last_y_ff;
   logic               open_ff;
   logic [COORD_W-1:0] cur_x_ff, cur_y_ff;

   logic [COORD_W-1:0] pt_x, pt_y;
   logic               is_mark;

   always_comb begin
      is_mark = 1'b0;
      case (cmd.src)
         SRC_END:   begin pt_x = ex_ff;      pt_y = ey_ff;      end
         SRC_START: begin pt_x = start_x_ff; pt_y = start_y_ff; end
         SRC_FIRST: begin pt_x = first_x_ff; pt_y = first_y_ff; end
         SRC_CURVE: begin pt_x = cur_x_ff;   pt_y = cur_y_ff;   end
         default: begin
            pt_x    = '0;
            pt_y    = '0;
            is_mark = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
         open_ff    <= 1'b0;
      end else if (cmd.clear_path) begin
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         last_x_ff  <= '0;
         last_y_ff  <= '0;
      end else if (cmd.emit) begin
         if (is_mark) begin
            open_ff <= 1'b0;
         end else begin
            // A point with no subpath open starts one and becomes its first point.
            if (!open_ff) begin
               open_ff    <= 1'b1;
               first_x_ff <= pt_x;
               first_y_ff <= pt_y;
            end
            last_x_ff <= pt_x;
            last_y_ff <= pt_y;
         end
         case (cmd.pen_op)
            PEN_END: begin
               pen_x_ff <= ex_ff;
               pen_y_ff <= ey_ff;
            end
            PEN_START: begin
               pen_x_ff <= start_x_ff;
               pen_y_ff <= start_y_ff;
            end
            default: begin
               pen_x_ff <= pen_x_ff;
            end
         endcase
         if (cmd.set_start) begin
            start_x_ff <= ex_ff;
            start_y_ff <= ey_ff;
         end
      end
   end

   // result register
   logic                rsp_valid_ff;
   logic [COORD_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic                rsp_last_ff;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_x_ff    <= pt_x;
         rsp_y_ff    <= pt_y;
         rsp_kind_ff <= is_mark ? KIND_MARK : (open_ff ? KIND_CONT : KIND_FIRST);
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_point_kind  = rsp_kind_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // curve weights: j = n - i, cubic j^3, 3j^2i, 3ji^2, i^3; quadratic j^2, 2ji, i^2
   logic [SEG_W-1:0]   n_ff, i_ff;
   logic [2*SEG_W-1:0] jj_ff, ii_ff, ji_ff, nn_ff;
   logic [WT_W-1:0]    w_ff [4];
   logic [WT_W-1:0]    den_ff;
   logic               cubic;
   logic [SEG_W-1:0]   j_val;

   assign cubic = (func_ff == FUNC_CUBIC);
   assign j_val = n_ff - i_ff;

   always_ff @(posedge clock) begin
      if (cmd.init_curve) begin
         n_ff <= seg_n;
         i_ff <= SEG_W'(1);
      end else if (cmd.seg_next) begin
         i_ff <= i_ff + SEG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wt_a) begin
         jj_ff <= (2*SEG_W)'(j_val) * (2*SEG_W)'(j_val);
         ii_ff <= (2*SEG_W)'(i_ff) * (2*SEG_W)'(i_ff);
         ji_ff <= (2*SEG_W)'(j_val) * (2*SEG_W)'(i_ff);
         nn_ff <= (2*SEG_W)'(n_ff) * (2*SEG_W)'(n_ff);
      end
      if (cmd.wt_b) begin
         if (cubic) begin
            w_ff[0] <= WT_W'(jj_ff) * WT_W'(j_val);
            w_ff[1] <= WT_W'(WT_W'(3) * jj_ff * i_ff);
            w_ff[2] <= WT_W'(WT_W'(3) * ii_ff * j_val);
            w_ff[3] <= WT_W'(ii_ff) * WT_W'(i_ff);
            den_ff  <= WT_W'(nn_ff) * WT_W'(n_ff);
         end else begin
            w_ff[0] <= WT_W'(jj_ff);
            w_ff[1] <= WT_W'(WT_W'(2) * ji_ff);
            w_ff[2] <= WT_W'(ii_ff);
            w_ff[3] <= '0;
            den_ff  <= WT_W'(nn_ff);
         end
      end
   end

   // multiply-accumulate, one term per cycle
   logic [1:0]          k_ff;
   logic                axis_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [COORD_W-1:0]  op_sel;
   logic signed [PROD_W-1:0] prod;

   always_comb begin
      case (k_ff)
         2'd0:    op_sel = axis_ff ? pen_y_ff : pen_x_ff;
         2'd1:    op_sel = axis_ff ? c1y_ff : c1x_ff;
         2'd2:    op_sel = cubic ? (axis_ff ? c2y_ff : c2x_ff) : (axis_ff ? ey_ff : ex_ff);
         default: op_sel = axis_ff ? ey_ff : ex_ff;
      endcase
   end

   assign prod = $signed(op_sel) * $signed({1'b0, w_ff[k_ff]});

   // divider: floor((2*acc + den) / (2*den)), magnitude restoring division
   logic signed [DV_W-1:0] num;
   logic [DV_W-1:0]        mag;
   logic                   neg_ff;
   logic [RM_W-1:0]        rem_ff, rem_t, rem_n;
   logic [QB-1:0]          quo_ff, quo_n, q_mag;
   logic [WT_W:0]          dvs_ff;
   logic [DCNT_W-1:0]      dcnt_ff;
   logic                   ge, div_done;
   logic [QB-1:0]          q_res;

   assign num = ($signed({{(DV_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff}) <<< 1)
              + $signed({{(DV_W-WT_W){1'b0}}, den_ff});
   assign mag = num[DV_W-1] ? DV_W'(-num) : DV_W'(num);

   assign rem_t    = {rem_ff[RM_W-2:0], quo_ff[QB-1]};
   assign ge       = rem_t >= {1'b0, dvs_ff};
   assign rem_n    = ge ? rem_t - {1'b0, dvs_ff} : rem_t;
   assign quo_n    = {quo_ff[QB-2:0], ge};
   assign div_done = cmd.div_step && (dcnt_ff == DCNT_W'(QB - 1));
   // Negative dividends need the ceiling of the magnitude to get a floor.
   assign q_mag    = quo_n + QB'(neg_ff && (rem_n != '0));
   assign q_res    = neg_ff ? QB'(-q_mag) : q_mag;

   always_ff @(posedge clock) begin
      if (cmd.wt_b) begin
         acc_ff  <= '0;
         k_ff    <= '0;
         axis_ff <= 1'b0;
      end else if (cmd.mac_step) begin
         acc_ff <= acc_ff + ACC_W'(prod);
         k_ff   <= k_ff + 2'd1;
      end else if (div_done) begin
         acc_ff  <= '0;
         k_ff    <= '0;
         axis_ff <= !axis_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         neg_ff  <= num[DV_W-1];
         rem_ff  <= RM_W'(mag >> QB);
         quo_ff  <= mag[QB-1:0];
         dvs_ff  <= {den_ff, 1'b0};
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_n;
         quo_ff  <= quo_n;
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         if (axis_ff) cur_y_ff <= q_res[COORD_W-1:0];
         else         cur_x_ff <= q_res[COORD_W-1:0];
      end
   end

   always_comb begin
      sts               = '0;
      sts.func          = func_ff;
      sts.open          = open_ff;
      sts.pen_eq_start  = (pen_x_ff == start_x_ff) && (pen_y_ff == start_y_ff);
      sts.first_eq_last = (first_x_ff == last_x_ff) && (first_y_ff == last_y_ff);
      sts.close_at_end  = cae_ff;
      sts.out_free      = out_free;
      sts.mac_last      = cmd.mac_step && (k_ff == 2'd3);
      sts.div_done      = div_done;
      sts.axis          = axis_ff;
      sts.seg_last      = (i_ff == n_ff);
   end

   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_MARK) |-> (rsp_x_ff == '0) && (rsp_y_ff == '0))
      else $error("subpath end marker carries a nonzero point");

   a_point_opens: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !is_mark |=> open_ff)
      else $error("emitted point did not leave a subpath open");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_step |-> (i_ff != '0) && (i_ff <= n_ff))
      else $error("curve index out of range during accumulation");

endmodule

// ===== rtl/core/bezier_path_flattener_core.sv =====
// ----------------------------------------------------------------------------
// bezier_path_flattener_core
// Flattens move/line/cubic/quadratic/close/end path commands into a stream
// of Q16.16 polyline points with subpath kinds.
// ----------------------------------------------------------------------------
//  channel   ports                               direction
//  req       req_valid/ready, func, coords       in:  one path command
//  rsp       rsp_valid/ready, point, kind, last  out: one polyline point
//  csr       csr_valid/ready, index, wdata       in:  register write
//
// Move, line, close and end commands are decoded and then emit their points, if
// any. For each point a curve runs two weight steps, then per coordinate
// four multiply-accumulate steps, a divider load and 33 divide steps, then
// one emit step.
// Reset is synchronous and returns the path state and registers to defaults.
// A stalled rsp holds the sequencer at its next emit; one result is buffered.
// ----------------------------------------------------------------------------
module bezier_path_flattener_core
   import bpf_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic [COORD_W-1:0]   req_end_x,
   input  logic [COORD_W-1:0]   req_end_y,
   input  logic [COORD_W-1:0]   req_ctrl1_x,
   input  logic [COORD_W-1:0]   req_ctrl1_y,
   input  logic [COORD_W-1:0]   req_ctrl2_x,
   input  logic [COORD_W-1:0]   req_ctrl2_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COORD_W-1:0]   rsp_point_x,
   output logic [COORD_W-1:0]   rsp_point_y,
   output logic [KIND_W-1:0]    rsp_point_kind,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEG_CFG_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   assign csr_ready = 1'b1;

   bpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bpf_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_ctrl1_x     (req_ctrl1_x),
      .req_ctrl1_y     (req_ctrl1_y),
      .req_ctrl2_x     (req_ctrl2_x),
      .req_ctrl2_y     (req_ctrl2_y),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_kind  (rsp_point_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ===== tb/bezier_path_flattener_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_path_flattener_core_checker
// Watches the command, point and register channels of the path flattener,
// predicts the polyline points of every accepted command and compares each
// accepted point with the oldest one predicted.
// ----------------------------------------------------------------------------
module bezier_path_flattener_core_checker
   import bpf_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic [COORD_W-1:0]   req_end_x,
   input  logic [COORD_W-1:0]   req_end_y,
   input  logic [COORD_W-1:0]   req_ctrl1_x,
   input  logic [COORD_W-1:0]   req_ctrl1_y,
   input  logic [COORD_W-1:0]   req_ctrl2_x,
   input  logic [COORD_W-1:0]   req_ctrl2_y,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [COORD_W-1:0]   rsp_point_x,
   input  logic [COORD_W-1:0]   rsp_point_y,
   input  logic [KIND_W-1:0]    rsp_point_kind,
   input  logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEG_CFG_W-1:0] csr_wdata,
   output int                   error_count,
   output int                   points_pending
);

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      kind_type           kind;
      logic               last;
   } poly_point_type;

   poly_point_type expected_points[$];

   logic [SEG_CFG_W-1:0] seg_cfg;
   logic                 close_cfg;
   longint pen_x, pen_y, start_x, start_y, first_x, first_y, last_x, last_y;
   bit     path_open;

   assign points_pending = expected_points.size();

   function automatic longint round_div(longint num, longint den);
      longint a, b, q;
      a = 2 * num + den;
      b = 2 * den;
      q = a / b;
      // Division truncates; pull negative quotients down to round half up.
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
   endfunction

   function automatic void push_point(longint x, longint y);
      poly_point_type p;
      p.x = x[COORD_W-1:0];
      p.y = y[COORD_W-1:0];
      p.last = 1'b0;
      if (path_open) begin
         p.kind = KIND_CONT;
      end else begin
         p.kind = KIND_FIRST;
         path_open = 1'b1;
         first_x = x;
         first_y = y;
      end
      last_x = x;
      last_y = y;
      expected_points.insert(expected_points.size(), p);
   endfunction

   function automatic void push_marker();
      poly_point_type p;
      p.x = '0;
      p.y = '0;
      p.kind = KIND_MARK;
      p.last = 1'b0;
      path_open = 1'b0;
      expected_points.insert(expected_points.size(), p);
   endfunction

   function automatic void flatten_command(logic [2:0] f, longint ex, longint ey,
                                           longint c1x, longint c1y,
                                           longint c2x, longint c2y);
      longint n, i, j, w0, w1, w2, w3, d;
      int     before_cnt;
      before_cnt = expected_points.size();
      n = (seg_cfg == 0) ? 1 : longint'(seg_cfg);
      if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
      case (f)
         FUNC_MOVE: begin
            if (path_open) push_marker();
            pen_x = ex; pen_y = ey;
            start_x = ex; start_y = ey;
            push_point(ex, ey);
         end
         FUNC_LINE: begin
            pen_x = ex; pen_y = ey;
            push_point(ex, ey);
         end
         FUNC_CUBIC: begin
            d = n * n * n;
            for (i = 1; i <= n; i++) begin
               j = n - i;
               w0 = j * j * j; w1 = 3 * j * j * i; w2 = 3 * j * i * i; w3 = i * i * i;
               push_point(round_div(w0 * pen_x + w1 * c1x + w2 * c2x + w3 * ex, d),
                          round_div(w0 * pen_y + w1 * c1y + w2 * c2y + w3 * ey, d));
            end
            pen_x = ex; pen_y = ey;
         end
         FUNC_QUAD: begin
            d = n * n;
            for (i = 1; i <= n; i++) begin
               j = n - i;
               w0 = j * j; w1 = 2 * j * i; w2 = i * i;
               push_point(round_div(w0 * pen_x + w1 * c1x + w2 * ex, d),
                          round_div(w0 * pen_y + w1 * c1y + w2 * ey, d));
            end
            pen_x = ex; pen_y = ey;
         end
         FUNC_CLOSE: begin
            if (pen_x != start_x || pen_y != start_y) begin
               push_point(start_x, start_y);
               pen_x = start_x;
               pen_y = start_y;
            end
            if (path_open) push_marker();
         end
         FUNC_END: begin
            if (path_open) begin
               if (close_cfg && (first_x != last_x || first_y != last_y))
                  push_point(first_x, first_y);
               push_marker();
            end
            pen_x = 0; pen_y = 0; start_x = 0; start_y = 0;
            first_x = 0; first_y = 0; last_x = 0; last_y = 0;
         end
         default: ;
      endcase
      if (expected_points.size() > before_cnt)
         expected_points[expected_points.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      poly_point_type p;
      if (reset) begin
         seg_cfg <= SEG_CFG_RESET;
         close_cfg <= 1'b0;
         pen_x = 0; pen_y = 0; start_x = 0; start_y = 0;
         first_x = 0; first_y = 0; last_x = 0; last_y = 0;
         path_open = 1'b0;
         expected_points.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SEGMENT_COUNT: seg_cfg <= csr_wdata;
               CSR_CLOSE_AT_END:  close_cfg <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            flatten_command(req_func,
                            longint'($signed(req_end_x)), longint'($signed(req_end_y)),
                            longint'($signed(req_ctrl1_x)), longint'($signed(req_ctrl1_y)),
                            longint'($signed(req_ctrl2_x)), longint'($signed(req_ctrl2_y)));
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               error_count++;
               $display("%0t: unexpected point x=%h y=%h kind=%0d last=%b", $time,
                        rsp_point_x, rsp_point_y, rsp_point_kind, rsp_last_of_run);
            end else begin
               p = expected_points.pop_front();
               if (rsp_point_x !== p.x) begin
                  error_count++;
                  $display("%0t: point_x expected %h actual %h", $time, p.x, rsp_point_x);
               end
               if (rsp_point_y !== p.y) begin
                  error_count++;
                  $display("%0t: point_y expected %h actual %h", $time, p.y, rsp_point_y);
               end
               if (rsp_point_kind !== p.kind) begin
                  error_count++;
                  $display("%0t: point_kind expected %0d actual %0d", $time,
                           p.kind, rsp_point_kind);
               end
               if (rsp_last_of_run !== p.last) begin
                  error_count++;
                  $display("%0t: last_of_run expected %b actual %b", $time,
                           p.last, rsp_last_of_run);
               end
            end
         end
      end
   end

   initial error_count = 0;

endmodule

// ===== tb/bezier_path_flattener_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_path_flattener_core_tb
// Drives directed and random path command sequences through the flattener
// under several register settings, with random gaps and output stalls, and
// reports the verdict of the point checker.
// ----------------------------------------------------------------------------
module bezier_path_flattener_core_tb;
   import bpf_pkg::*;

   localparam logic [2:0] FUNC_SPARE6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE7 = 3'd7;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int SETTLE_CYCLES = 30;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [2:0]           req_func;
   logic [COORD_W-1:0]   req_end_x, req_end_y;
   logic [COORD_W-1:0]   req_ctrl1_x, req_ctrl1_y, req_ctrl2_x, req_ctrl2_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [COORD_W-1:0]   rsp_point_x, rsp_point_y;
   logic [KIND_W-1:0]    rsp_point_kind;
   logic                 rsp_last_of_run;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SEG_CFG_W-1:0] csr_wdata;
   int                   error_count;
   int                   points_pending;

   int  cmds_sent;
   int  cycle_count;
   bit  quiet_send;
   bit  quiet_recv;
   bit  long_hold_done;
   logic [COORD_W-1:0] coord_pool[4];

   bezier_path_flattener_core u_dut (.*);

   bezier_path_flattener_core_checker u_checker (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      req_valid = 1'b0; req_func = '0;
      req_end_x = '0; req_end_y = '0;
      req_ctrl1_x = '0; req_ctrl1_y = '0; req_ctrl2_x = '0; req_ctrl2_y = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_wdata = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
   initial cycle_count = 0;

   // Output side: random stalls, one long hold-off so the block backs up.
   initial begin
      int hold_cnt;
      long_hold_done = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && cmds_sent >= 60) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            for (hold_cnt = 0; hold_cnt < 600; hold_cnt++) @(posedge clock);
         end
         if (!quiet_recv && $urandom_range(99) < 14) rsp_ready <= 1'b0;
         else rsp_ready <= 1'b1;
      end
   end

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(4))
         0, 1: return $urandom;
         2: return $urandom_range(2097152) - 1048576;
         3: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return coord_pool[$urandom_range(3)];
      endcase
   endfunction

   task automatic send_cmd(input logic [2:0] f,
                           input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                           input logic [COORD_W-1:0] c1x, input logic [COORD_W-1:0] c1y,
                           input logic [COORD_W-1:0] c2x, input logic [COORD_W-1:0] c2y);
      while (!quiet_send && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_end_x <= ex; req_end_y <= ey;
      req_ctrl1_x <= c1x; req_ctrl1_y <= c1y;
      req_ctrl2_x <= c2x; req_ctrl2_y <= c2y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cmds_sent++;
   endtask

   task automatic send_rand(input logic [2:0] f);
      send_cmd(f, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord());
   endtask

   // Lets the block drain completely, then writes both registers.
   task automatic set_registers(input logic [SEG_CFG_W-1:0] seg, input logic close_end);
      req_valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_SEGMENT_COUNT;
      csr_wdata <= seg;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_CLOSE_AT_END;
      csr_wdata <= {{(SEG_CFG_W-1){1'b0}}, close_end};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_path();
      int k, steps;
      logic [COORD_W-1:0] sx, sy;
      sx = pick_coord();
      sy = pick_coord();
      send_cmd(FUNC_MOVE, sx, sy, pick_coord(), pick_coord(), pick_coord(), pick_coord());
      steps = $urandom_range(1, 5);
      for (k = 0; k < steps; k++) begin
         case ($urandom_range(5))
            0, 1: send_rand(FUNC_LINE);
            2:    send_rand(FUNC_CUBIC);
            3:    send_rand(FUNC_QUAD);
            // Back to the subpath start, so a close straight after it has nothing to add.
            default: send_cmd(FUNC_LINE, sx, sy, $urandom, $urandom, $urandom, $urandom);
         endcase
      end
      case ($urandom_range(4))
         0, 1: send_rand(FUNC_CLOSE);
         2, 3: send_rand(FUNC_END);
         default: ;
      endcase
   endtask

   task automatic random_phase(input logic [SEG_CFG_W-1:0] seg, input logic close_end,
                               input int cmd_quota);
      int target;
      set_registers(seg, close_end);
      target = cmds_sent + cmd_quota;
      while (cmds_sent < target) begin
         if ($urandom_range(9) == 0) begin
            // Noise: any function code, including the unused ones.
            send_rand(3'($urandom_range(7)));
         end else begin
            random_path();
         end
      end
   endtask

   initial begin
      int p;
      cmds_sent = 0;
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      for (p = 0; p < 4; p++) coord_pool[p] = $urandom;
      @(negedge reset);
      @(posedge clock);
      set_registers(SEG_CFG_RESET, 1'b0);

      // Nothing open: close and end produce no points; spare codes are ignored.
      send_rand(FUNC_CLOSE);
      send_rand(FUNC_END);
      send_rand(FUNC_SPARE6);
      send_rand(FUNC_SPARE7);
      // A line with no open subpath opens one.
      send_cmd(FUNC_LINE, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0, '0);
      send_cmd(FUNC_CUBIC, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000, 32'h7fff_ffff);
      send_cmd(FUNC_QUAD, 32'hffff_ffff, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
               '0, '0);
      // Move on an open subpath ends it first.
      send_cmd(FUNC_MOVE, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0, '0);
      send_cmd(FUNC_LINE, '0, '0, '0, '0, '0, '0);
      send_rand(FUNC_CLOSE);
      send_rand(FUNC_CLOSE);
      send_cmd(FUNC_MOVE, 32'd5, 32'd5, '0, '0, '0, '0);
      send_rand(FUNC_CLOSE);
      send_cmd(FUNC_MOVE, 32'd1, 32'd1, '0, '0, '0, '0);
      send_cmd(FUNC_LINE, 32'd2, 32'd2, '0, '0, '0, '0);
      send_rand(FUNC_END);

      // A segment count of zero acts as one; end closes back to the first point.
      set_registers('0, 1'b1);
      send_cmd(FUNC_MOVE, 32'h0003_0000, 32'hfffd_0000, '0, '0, '0, '0);
      send_rand(FUNC_CUBIC);
      send_rand(FUNC_QUAD);
      send_rand(FUNC_END);
      send_cmd(FUNC_MOVE, 32'h0003_0000, 32'hfffd_0000, '0, '0, '0, '0);
      send_cmd(FUNC_LINE, 32'h0004_0000, 32'h0004_0000, '0, '0, '0, '0);
      send_cmd(FUNC_LINE, 32'h0003_0000, 32'hfffd_0000, '0, '0, '0, '0);
      send_rand(FUNC_END);

      // Large counts are slow per curve, so those phases stay short.
      random_phase(7'd127, 1'b0, 8);
      random_phase(7'd3, 1'b1, 60);
      random_phase(7'd64, 1'b1, 8);
      quiet_send = 1'b1;
      quiet_recv = 1'b1;
      random_phase(7'd2, 1'b0, 60);
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      random_phase(7'd1, 1'b1, 60);
      random_phase(7'd5, 1'b0, 60);
      random_phase(7'd8, 1'b1, 60);
      random_phase(7'd4, 1'b0, 60);

      req_valid <= 1'b0;
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
